FILE: design/msp_pkg.sv
`default_nettype none

package msp_pkg;

  localparam int unsigned DivW    = 28;
  localparam int unsigned DivCntW = 5;
  localparam int unsigned DvsrW   = 16;

  localparam logic [15:0] SpeedScaleRst = 16'd1875;
  localparam logic [15:0] PulsesRevRst  = 16'd40;
  localparam logic [9:0]  AgreeWinRst   = 10'd128;

  localparam logic [14:0] SpeedSat     = 15'd32767;
  localparam logic [11:0] DriveMax     = 12'd2084;
  localparam logic [11:0] SpOffset     = 12'd211;
  localparam logic [15:0] SpGain       = 16'd9;
  localparam logic [7:0]  SpMinCmd     = 8'd49;
  localparam logic [11:0] DutyMinDrive = 12'd230;
  localparam logic [7:0]  DutyMax      = 8'd255;
  // ceil(2^15 / 9), exact for dividends up to 2295
  localparam logic [11:0] DutyRecip    = 12'd3641;

  localparam logic signed [17:0] SumHi  = 18'sd20000;
  localparam logic signed [17:0] SumLo  = -18'sd20000;
  localparam logic signed [19:0] PidMax = 20'sd2084;

  localparam logic [DivCntW-1:0] SpeedSteps = DivCntW'(DivW);

  typedef enum logic [1:0] {
    REG_SPEED_SCALE    = 2'd0,
    REG_PULSES_PER_REV = 2'd1,
    REG_AGREE_WINDOW   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic                 start;
    logic [DivW-1:0]      dividend;
    logic [DvsrW-1:0]     divisor;
    logic [DivCntW-1:0]   steps;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DivW-1:0]      quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: design/msp_div.sv
`default_nettype none

module msp_div
  import msp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic [DivW-1:0]    dvd_q, dvd_d;
  logic [DivW-1:0]    quo_q, quo_d;
  logic [DvsrW-1:0]   rem_q, rem_d;
  logic [DvsrW-1:0]   dvs_q, dvs_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DvsrW:0]     trial;
  logic [DvsrW:0]     diff;
  logic               fits;

  assign trial = {rem_q, dvd_q[DivW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      quo_d  = '0;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DivW-2:0], 1'b0};
      quo_d = {quo_q[DivW-2:0], fits};
      rem_d = fits ? diff[DvsrW-1:0] : trial[DvsrW-1:0];
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

FILE: design/motor_speed_pid_tick.sv
`default_nettype none
// Motor speed PID, one control tick per input beat.
// Input stream: one beat per tick carrying the encoder pulse count and two
// redundant potentiometer readings. Output stream: one beat per tick with the
// PWM duty, measured and target speed, clamped drive level and direction flag.
// Config port: speed_scale, pulses_per_rev and agree_window. The user must
// write them only while no tick is in progress; the block does not enforce
// this. Index 3 is ignored. Most of a tick is spent in the serial divider:
// 28 steps for the speed division; the duty division by 9 is a combinational
// reciprocal multiply.
// s_axis_tready_o is high only while the sequencer is idle.
// The result sits in an output register; if the receiver stalls, the result
// of the next tick waits in the final state until that register drains.
// Reset clears the integral sum, the previous error, the output valid flag
// and restores the register defaults (1875, 40, 128).
module motor_speed_pid_tick
  import msp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // pulse_count[11:0], adc_a[21:12], adc_b[31:22]
  input  wire logic [31:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // duty[7:0], measured_speed[22:8], target_speed[34:23], drive_level[46:35],
  // forward_drive[47]
  output logic [47:0]      m_axis_tdata_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_SPD  = 6'b000100,
    S_PID  = 6'b001000,
    S_DUTY = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] scale_q;
  logic [15:0] ppr_q;
  logic [9:0]  window_q;

  logic signed [15:0] sum_q, sum_d;
  logic signed [16:0] prev_q, prev_d;

  logic [11:0] pulses_q, pulses_d;
  logic [11:0] target_q, target_d;
  logic [14:0] speed_q, speed_d;
  logic [11:0] drive_q, drive_d;
  logic        fwd_q, fwd_d;
  logic [7:0]  duty_q, duty_d;

  logic        m_valid_q, m_valid_d;
  logic [47:0] m_data_q, m_data_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [9:0]  adc_a, adc_b, adc_diff;
  logic [10:0] adc_sum;
  logic [7:0]  cmd;
  logic [11:0] target_new;

  logic signed [16:0] err;
  logic signed [17:0] deriv;
  logic signed [19:0] pid;
  logic signed [17:0] isum;
  logic [11:0]        duty_dvd;
  logic [23:0]        duty_prod;

  msp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // setpoint from the potentiometer pair
  assign adc_a    = s_axis_tdata_i[21:12];
  assign adc_b    = s_axis_tdata_i[31:22];
  assign adc_sum  = {1'b0, adc_a} + {1'b0, adc_b};
  assign adc_diff = (adc_a > adc_b) ? (adc_a - adc_b) : (adc_b - adc_a);
  assign cmd      = (adc_diff < window_q) ? adc_sum[10:3] : 8'd0;
  assign target_new = (cmd < SpMinCmd) ? 12'd0
                    : ({1'b0, cmd, 3'b000} + {4'b0000, cmd}) - SpOffset;

  // PID terms
  assign err   = $signed({5'b00000, target_q}) - $signed({2'b00, speed_q});
  assign deriv = 18'(err) - 18'(prev_q);
  assign pid   = 20'(err >>> 1) + 20'(sum_q >>> 3) + 20'(sum_q >>> 4)
               + 20'(deriv >>> 3) + 20'(deriv >>> 4);
  assign isum  = 18'(sum_q) + 18'(err);

  // divide by 9: multiply by the reciprocal, keep bits 15 and up
  assign duty_dvd  = drive_q + SpOffset;
  assign duty_prod = 24'(duty_dvd) * 24'(DutyRecip);

  always_comb begin
    state_d  = state_q;
    pulses_d = pulses_q;
    target_d = target_q;
    speed_d  = speed_q;
    drive_d  = drive_q;
    fwd_d    = fwd_q;
    duty_d   = duty_q;
    sum_d    = sum_q;
    prev_d   = prev_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    div_req   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          pulses_d = s_axis_tdata_i[11:0];
          target_d = target_new;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = DivW'(scale_q) * DivW'(pulses_q);
        div_req.divisor  = ppr_q;
        div_req.steps    = SpeedSteps;
        state_d          = S_SPD;
      end
      S_SPD: begin
        if (div_rsp.done) begin
          if ((ppr_q == 16'd0) || (|div_rsp.quotient[DivW-1:15])) begin
            speed_d = SpeedSat;
          end else begin
            speed_d = div_rsp.quotient[14:0];
          end
          state_d = S_PID;
        end
      end
      S_PID: begin
        fwd_d = (pid > 20'sd0) && (pid < PidMax);
        priority if (pid >= PidMax) begin
          drive_d = DriveMax;
        end else if (pid > 20'sd0) begin
          drive_d = pid[11:0];
        end else begin
          drive_d = 12'd0;
        end
        prev_d = err;
        priority if (isum > SumHi) begin
          sum_d = 16'(SumHi);
        end else if (isum < SumLo) begin
          sum_d = 16'(SumLo);
        end else begin
          sum_d = isum[15:0];
        end
        state_d = S_DUTY;
      end
      S_DUTY: begin
        priority if (drive_q < DutyMinDrive) begin
          duty_d = 8'd0;
        end else if (duty_prod[23]) begin
          duty_d = DutyMax;
        end else begin
          duty_d = duty_prod[22:15];
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {fwd_q, drive_q, target_q, speed_q, duty_q};
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sum_q     <= '0;
      prev_q    <= '0;
      m_valid_q <= 1'b0;
      scale_q   <= SpeedScaleRst;
      ppr_q     <= PulsesRevRst;
      window_q  <= AgreeWinRst;
    end else begin
      state_q   <= state_d;
      sum_q     <= sum_d;
      prev_q    <= prev_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SPEED_SCALE:    scale_q  <= cfg_data_i;
          REG_PULSES_PER_REV: ppr_q    <= cfg_data_i;
          REG_AGREE_WINDOW:   window_q <= cfg_data_i[9:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pulses_q <= pulses_d;
    target_q <= target_d;
    speed_q  <= speed_d;
    drive_q  <= drive_d;
    fwd_q    <= fwd_d;
    duty_q   <= duty_d;
    m_data_q <= m_data_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

`default_nettype wire

FILE: design/msp_chk.sv
`default_nettype none

module msp_chk
  import msp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_i,
  input wire logic        m_axis_tvalid_i,
  input wire logic        m_axis_tready_i,
  input wire logic [47:0] m_axis_tdata_i
);

  // one tick at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_i) |=> !s_axis_tready_i)
    else $error("input accepted while a tick is in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && !m_axis_tready_i) |=> (m_axis_tvalid_i && $stable(m_axis_tdata_i)))
    else $error("stalled output beat changed");

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> (m_axis_tdata_i[46:35] <= DriveMax))
    else $error("drive level above limit");

  a_fwd_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && m_axis_tdata_i[47]) |->
      ((m_axis_tdata_i[46:35] != 12'd0) && (m_axis_tdata_i[46:35] != DriveMax)))
    else $error("forward flag with drive at a limit");

  a_duty_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && (m_axis_tdata_i[46:35] < DutyMinDrive)) |->
      (m_axis_tdata_i[7:0] == 8'd0))
    else $error("nonzero duty below minimum drive");

endmodule

bind motor_speed_pid_tick msp_chk u_msp_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);

`default_nettype wire
